@@ rtl/core/jddm_pkg.sv @@
// ---------------------------------------------------------------------------
// jddm_pkg
// Shared widths, stage positions, register codes and types for the
// joystick differential drive mixer.
// ---------------------------------------------------------------------------
package jddm_pkg;

	// configuration port
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;
	localparam int DZ_W      = 8;
	localparam int CAP_W     = 9;
	localparam logic [DZ_W-1:0]  DZ_RESET  = 8'd10;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd511;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADZONE  = 1'b0,
		REG_SPEED_CAP = 1'b1
	} cfg_reg_t;

	// datapath widths
	localparam int AXQ_W = 10;            // scaled axis magnitude, up to 512
	localparam int SQ_W  = 19;            // axis squared, up to 2^18
	localparam int S_W   = 20;            // x^2 + y^2
	localparam int RT_W  = 18;            // root with 8 fraction bits
	localparam int RAD_W = 2 * RT_W + 1;  // root remainder
	localparam int FR_W  = 8;             // fraction bits of the root
	localparam int D8_W  = CAP_W + FR_W;  // capped root
	localparam int PR_W  = D8_W + SQ_W;   // root times difference
	localparam int NM_W  = PR_W - FR_W;   // dividend of the mix divider
	localparam int MAG_W = 9;             // motor magnitude
	localparam int MQ_W  = MAG_W;         // mix quotient bits

	// pipeline stage positions
	localparam int P_IN   = 0;
	localparam int P_AX   = P_IN + 1;
	localparam int P_SQR  = P_AX + AXQ_W;
	localparam int P_RT   = P_SQR + 1;
	localparam int P_CAP  = P_RT + RT_W;
	localparam int P_MUL  = P_CAP + 1;
	localparam int P_MD   = P_MUL + 1;
	localparam int P_OUT  = P_MD + MQ_W;
	localparam int NSTG   = P_OUT + 1;

	// per-item flags that ride along once the axes are known
	typedef struct packed {
		logic halve;
		logic y_neg;
		logic mix_left;
	} side_t;

endpackage

@@ rtl/core/jddm_stick_if.sv @@
// ---------------------------------------------------------------------------
// jddm_stick_if
// Joystick sample channel: valid/ready handshake with two ADC readings and
// the halve-speed flag.
// ---------------------------------------------------------------------------
interface jddm_stick_if #(
	parameter int ADC_WIDTH = 10
) ();
	logic                 valid;
	logic                 ready;
	logic [ADC_WIDTH-1:0] stick_x;
	logic [ADC_WIDTH-1:0] stick_y;
	logic                 halve_speed;

	modport source (output valid, output stick_x, output stick_y, output halve_speed,
		input ready);
	modport sink (input valid, input stick_x, input stick_y, input halve_speed,
		output ready);
endinterface

@@ rtl/core/jddm_motor_if.sv @@
// ---------------------------------------------------------------------------
// jddm_motor_if
// Motor command channel: valid/ready handshake with left and right
// magnitudes and directions.
// ---------------------------------------------------------------------------
interface jddm_motor_if ();
	logic                        valid;
	logic                        ready;
	logic [jddm_pkg::MAG_W-1:0]  left_magnitude;
	logic                        left_forward;
	logic [jddm_pkg::MAG_W-1:0]  right_magnitude;
	logic                        right_forward;

	modport source (output valid, output left_magnitude, output left_forward,
		output right_magnitude, output right_forward, input ready);
	modport sink (input valid, input left_magnitude, input left_forward,
		input right_magnitude, input right_forward, output ready);
endinterface

@@ rtl/core/joystick_differential_drive_mixer.sv @@
// ---------------------------------------------------------------------------
// joystick_differential_drive_mixer
// Arcade-to-tank mixing of a two-axis joystick sample into left and right
// motor commands, as a fully pipelined datapath.
// ---------------------------------------------------------------------------
// The pipeline holds the bit-per-stage axis divider (10), root extraction (18) and mix
// divider (9) stages plus five other stages.
// Throughput: one item per cycle; each stage holds only while the stage after
// it is full and stalled, so empty slots close up under back pressure.
// Reset: arst_n clears all stage valid bits, the deadzone half width to 10 and
// speed_cap to 511; datapath registers are not reset.
module joystick_differential_drive_mixer #(
	parameter int ADC_WIDTH = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [jddm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jddm_pkg::CFG_W-1:0]    cfg_data,
	jddm_stick_if.sink                    stick,
	jddm_motor_if.source                  motor
);

	localparam int MW    = (ADC_WIDTH > 9) ? ADC_WIDTH : 9;
	localparam int NUM_W = MW + 9;

	// axis divider lane
	typedef struct packed {
		logic [NUM_W-1:0]           rem;
		logic [MW-1:0]              den;
		logic [jddm_pkg::AXQ_W-1:0] q;
		logic                       neg;
		logic                       zero;
	} axd_t;

	typedef struct packed {
		axd_t x;
		axd_t y;
		logic halve;
	} ax_t;

	typedef struct packed {
		logic [jddm_pkg::RAD_W-1:0] rem;
		logic [jddm_pkg::RT_W-1:0]  root;
		logic [jddm_pkg::SQ_W-1:0]  xx;
		logic [jddm_pkg::SQ_W-1:0]  yy;
		logic [jddm_pkg::S_W-1:0]   s;
		jddm_pkg::side_t            side;
	} rt_t;

	typedef struct packed {
		logic [jddm_pkg::D8_W-1:0] d8;
		logic [jddm_pkg::SQ_W-1:0] diff;
		logic [jddm_pkg::S_W-1:0]  s;
		logic                      diff_neg;
		logic                      nz;
		jddm_pkg::side_t           side;
	} cp_t;

	typedef struct packed {
		logic [jddm_pkg::NM_W-1:0]  rem;
		logic [jddm_pkg::MQ_W-1:0]  q;
		logic [jddm_pkg::S_W-1:0]   s;
		logic [jddm_pkg::MAG_W-1:0] fm;
		logic                       diff_neg;
		logic                       nz;
		jddm_pkg::side_t            side;
	} md_t;

	typedef struct packed {
		logic [jddm_pkg::MAG_W-1:0] lm;
		logic                       lf;
		logic [jddm_pkg::MAG_W-1:0] rm;
		logic                       rf;
	} out_t;

	// one restoring divide step, quotient bit shifted in at the bottom
	function automatic axd_t ax_step(input axd_t a, input int sh);
		axd_t               r;
		logic [NUM_W:0]     t;
		r = a;
		t = (NUM_W+1)'(a.rem) - ((NUM_W+1)'(a.den) << sh);
		r.q = {a.q[jddm_pkg::AXQ_W-2:0], ~t[NUM_W]};
		if (!t[NUM_W]) begin
			r.rem = t[NUM_W-1:0];
		end
		return r;
	endfunction

	// configuration registers
	logic [jddm_pkg::DZ_W-1:0]  dz_q;
	logic [jddm_pkg::CAP_W-1:0] cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q  <= jddm_pkg::DZ_RESET;
			cap_q <= jddm_pkg::CAP_RESET;
		end else if (cfg_we) begin
			unique case (jddm_pkg::cfg_reg_t'(cfg_index))
				jddm_pkg::REG_DEADZONE:  dz_q  <= cfg_data[jddm_pkg::DZ_W-1:0];
				jddm_pkg::REG_SPEED_CAP: cap_q <= cfg_data[jddm_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// stage valid bits and per-stage enables
	logic [jddm_pkg::NSTG-1:0] v_q;
	logic [jddm_pkg::NSTG:0]   en;
	logic [jddm_pkg::NSTG-1:0] v_in;

	assign en[jddm_pkg::NSTG] = motor.ready;
	assign v_in = {v_q[jddm_pkg::NSTG-2:0], stick.valid};

	for (genvar k = 0; k < jddm_pkg::NSTG; k++) begin : g_en
		assign en[k] = ~v_q[k] | en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < jddm_pkg::NSTG; k++) begin
				if (en[k]) begin
					v_q[k] <= v_in[k];
				end
			end
		end
	end

	assign stick.ready = en[jddm_pkg::P_IN];
	assign motor.valid = v_q[jddm_pkg::P_OUT];

	// input stage: centre, deadzone test, divider operands
	logic [MW:0]          full_w;
	logic [MW:0]          dz2_w;
	logic [MW:0]          r2_x, r2_y, mag_x, mag_y;
	logic [NUM_W-1:0]     dif_x, dif_y;
	ax_t                  ax_in;
	ax_t                  ax_s [0:jddm_pkg::AXQ_W];

	always_comb begin
		full_w = (MW+1)'({ADC_WIDTH{1'b1}});
		dz2_w  = (MW+1)'({dz_q, 1'b0});
		r2_x   = (MW+1)'({stick.stick_x, 1'b0});
		r2_y   = (MW+1)'({stick.stick_y, 1'b0});
		ax_in.x.neg  = ~stick.stick_x[ADC_WIDTH-1];
		ax_in.y.neg  = ~stick.stick_y[ADC_WIDTH-1];
		mag_x  = ax_in.x.neg ? (full_w - r2_x) : (r2_x - full_w);
		mag_y  = ax_in.y.neg ? (full_w - r2_y) : (r2_y - full_w);
		ax_in.x.zero = (mag_x <= dz2_w);
		ax_in.y.zero = (mag_y <= dz2_w);
		dif_x  = NUM_W'(mag_x - dz2_w);
		dif_y  = NUM_W'(mag_y - dz2_w);
		ax_in.x.rem  = dif_x << 9;
		ax_in.y.rem  = dif_y << 9;
		ax_in.x.den  = MW'(full_w - dz2_w);
		ax_in.y.den  = MW'(full_w - dz2_w);
		ax_in.x.q    = '0;
		ax_in.y.q    = '0;
		ax_in.halve  = stick.halve_speed;
	end

	always_ff @(posedge clk) begin
		if (en[jddm_pkg::P_IN]) begin
			ax_s[0] <= ax_in;
		end
	end

	// axis divider, one quotient bit per stage
	for (genvar k = 0; k < jddm_pkg::AXQ_W; k++) begin : g_axdiv
		ax_t nxt;
		always_comb begin
			nxt   = ax_s[k];
			nxt.x = ax_step(ax_s[k].x, jddm_pkg::AXQ_W - 1 - k);
			nxt.y = ax_step(ax_s[k].y, jddm_pkg::AXQ_W - 1 - k);
		end
		always_ff @(posedge clk) begin
			if (en[jddm_pkg::P_AX + k]) begin
				ax_s[k+1] <= nxt;
			end
		end
	end

	// square stage: signed axes, squares, motor selection
	logic [jddm_pkg::AXQ_W-1:0] qx, qy;
	logic                       x_neg, x_zero;
	rt_t                        rt_in;
	rt_t                        rt_s [0:jddm_pkg::RT_W];

	always_comb begin
		qx     = ax_s[jddm_pkg::AXQ_W].x.zero ? '0 : ax_s[jddm_pkg::AXQ_W].x.q;
		qy     = ax_s[jddm_pkg::AXQ_W].y.zero ? '0 : ax_s[jddm_pkg::AXQ_W].y.q;
		x_zero = (qx == '0);
		x_neg  = ax_s[jddm_pkg::AXQ_W].x.neg & ~x_zero;
		rt_in.side.y_neg    = ax_s[jddm_pkg::AXQ_W].y.neg & (qy != '0);
		rt_in.side.halve    = ax_s[jddm_pkg::AXQ_W].halve;
		rt_in.side.mix_left = x_neg | (x_zero & ~rt_in.side.y_neg);
		rt_in.xx   = jddm_pkg::SQ_W'(qx * qx);
		rt_in.yy   = jddm_pkg::SQ_W'(qy * qy);
		rt_in.s    = jddm_pkg::S_W'(rt_in.xx) + jddm_pkg::S_W'(rt_in.yy);
		rt_in.rem  = jddm_pkg::RAD_W'(rt_in.s) << (2 * jddm_pkg::FR_W);
		rt_in.root = '0;
	end

	always_ff @(posedge clk) begin
		if (en[jddm_pkg::P_SQR]) begin
			rt_s[0] <= rt_in;
		end
	end

	// root extraction, one root bit per stage
	for (genvar k = 0; k < jddm_pkg::RT_W; k++) begin : g_root
		localparam int B = jddm_pkg::RT_W - 1 - k;
		logic [jddm_pkg::RAD_W-1:0] cand;
		logic                       take;
		rt_t                        nxt;
		always_comb begin
			cand = (jddm_pkg::RAD_W'(rt_s[k].root) << (2 * B + 2))
				| (jddm_pkg::RAD_W'(1) << (2 * B));
			take = (rt_s[k].rem >= cand);
			nxt  = rt_s[k];
			nxt.root = {rt_s[k].root[jddm_pkg::RT_W-2:0], take};
			if (take) begin
				nxt.rem = rt_s[k].rem - cand;
			end
		end
		always_ff @(posedge clk) begin
			if (en[jddm_pkg::P_RT + k]) begin
				rt_s[k+1] <= nxt;
			end
		end
	end

	// saturation and difference of squares
	logic [jddm_pkg::D8_W-1:0] cap8;
	cp_t                       cp_in;
	cp_t                       cp_s1;

	always_comb begin
		cap8 = {cap_q, {jddm_pkg::FR_W{1'b0}}};
		cp_in.d8 = (rt_s[jddm_pkg::RT_W].root > jddm_pkg::RT_W'(cap8)) ? cap8
			: jddm_pkg::D8_W'(rt_s[jddm_pkg::RT_W].root);
		cp_in.diff_neg = (rt_s[jddm_pkg::RT_W].xx > rt_s[jddm_pkg::RT_W].yy);
		cp_in.diff = cp_in.diff_neg
			? (rt_s[jddm_pkg::RT_W].xx - rt_s[jddm_pkg::RT_W].yy)
			: (rt_s[jddm_pkg::RT_W].yy - rt_s[jddm_pkg::RT_W].xx);
		cp_in.s    = rt_s[jddm_pkg::RT_W].s;
		cp_in.nz   = (rt_s[jddm_pkg::RT_W].s != '0);
		cp_in.side = rt_s[jddm_pkg::RT_W].side;
	end

	always_ff @(posedge clk) begin
		if (en[jddm_pkg::P_CAP]) begin
			cp_s1 <= cp_in;
		end
	end

	// multiply root by difference, drop the fraction bits
	logic [jddm_pkg::PR_W-1:0] prod;
	md_t                       md_in;
	md_t                       md_s [0:jddm_pkg::MQ_W];

	always_comb begin
		prod = jddm_pkg::PR_W'(cp_s1.d8) * jddm_pkg::PR_W'(cp_s1.diff);
		md_in.rem      = prod[jddm_pkg::PR_W-1:jddm_pkg::FR_W];
		md_in.q        = '0;
		md_in.s        = cp_s1.s;
		md_in.fm       = cp_s1.d8[jddm_pkg::D8_W-1:jddm_pkg::FR_W];
		md_in.diff_neg = cp_s1.diff_neg;
		md_in.nz       = cp_s1.nz;
		md_in.side     = cp_s1.side;
	end

	always_ff @(posedge clk) begin
		if (en[jddm_pkg::P_MUL]) begin
			md_s[0] <= md_in;
		end
	end

	// mix divider by x^2 + y^2, one quotient bit per stage
	for (genvar k = 0; k < jddm_pkg::MQ_W; k++) begin : g_mixdiv
		logic [jddm_pkg::NM_W:0] t;
		md_t                     nxt;
		always_comb begin
			t = (jddm_pkg::NM_W+1)'(md_s[k].rem)
				- ((jddm_pkg::NM_W+1)'(md_s[k].s) << (jddm_pkg::MQ_W - 1 - k));
			nxt   = md_s[k];
			nxt.q = {md_s[k].q[jddm_pkg::MQ_W-2:0], ~t[jddm_pkg::NM_W]};
			if (!t[jddm_pkg::NM_W]) begin
				nxt.rem = t[jddm_pkg::NM_W-1:0];
			end
		end
		always_ff @(posedge clk) begin
			if (en[jddm_pkg::P_MD + k]) begin
				md_s[k+1] <= nxt;
			end
		end
	end

	// output stage: signs, motor assignment, halving
	logic [jddm_pkg::MAG_W-1:0] mix_mag, full_mag, lm, rm;
	logic                       mix_neg, full_neg, ln, rn;
	out_t                       out_in;
	out_t                       out_q;

	always_comb begin
		mix_mag  = md_s[jddm_pkg::MQ_W].nz ? md_s[jddm_pkg::MQ_W].q  : '0;
		full_mag = md_s[jddm_pkg::MQ_W].nz ? md_s[jddm_pkg::MQ_W].fm : '0;
		full_neg = md_s[jddm_pkg::MQ_W].side.y_neg & (full_mag != '0);
		mix_neg  = (md_s[jddm_pkg::MQ_W].side.y_neg ^ md_s[jddm_pkg::MQ_W].diff_neg)
			& (mix_mag != '0);
		if (md_s[jddm_pkg::MQ_W].side.mix_left) begin
			lm = mix_mag;
			ln = mix_neg;
			rm = full_mag;
			rn = full_neg;
		end else begin
			lm = full_mag;
			ln = full_neg;
			rm = mix_mag;
			rn = mix_neg;
		end
		if (md_s[jddm_pkg::MQ_W].side.halve) begin
			lm = lm >> 1;
			rm = rm >> 1;
		end
		out_in.lm = lm;
		out_in.lf = ~ln;
		out_in.rm = rm;
		out_in.rf = ~rn;
	end

	always_ff @(posedge clk) begin
		if (en[jddm_pkg::P_OUT]) begin
			out_q <= out_in;
		end
	end

	assign motor.left_magnitude  = out_q.lm;
	assign motor.left_forward    = out_q.lf;
	assign motor.right_magnitude = out_q.rm;
	assign motor.right_forward   = out_q.rf;

endmodule
